// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define SPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// types, codes and defaults shared by the pattern replace block
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int WORD_W      = 32;
    localparam int PAT_MAX_DEF = 8;
    localparam int TXT_MAX_DEF = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    // operation codes of an input request
    localparam logic [1:0] OP_PAT = 2'd0;
    localparam logic [1:0] OP_TXT = 2'd1;
    localparam logic [1:0] OP_SEQ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLEN = 2'd1;

    typedef struct packed {
        logic [1:0]               kind;
        logic [2:0]               slot;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } t_qitem;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] plen;
        logic [CFG_DATA_W-1:0] tlen;
    } t_cfg;

endpackage

// ===== rtl/spr_intf.sv =====
// ----------------------------------------------------------------------------
// spr_intf
// stream and configuration channels of the pattern replace block
// ----------------------------------------------------------------------------
interface spr_in_if;
    import spr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [2:0]               slot;
    logic signed [WORD_W-1:0] word;
    logic                     final_word;

    modport source (output valid, operation, slot, word, final_word, input ready);
    modport sink (input valid, operation, slot, word, final_word, output ready);
endinterface

interface spr_out_if;
    import spr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] out_word;
    logic                     has_word;
    logic                     end_of_run;

    modport source (output valid, out_word, has_word, end_of_run, input ready);
    modport sink (input valid, out_word, has_word, end_of_run, output ready);
endinterface

interface spr_cfg_if;
    import spr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/spr_front.sv =====
// ----------------------------------------------------------------------------
// spr_front
// accepts input requests, drops unused codes and slots, feeds the queue
// ----------------------------------------------------------------------------
module spr_front #(
    parameter int PAT_MAX = spr_pkg::PAT_MAX_DEF,
    parameter int TXT_MAX = spr_pkg::TXT_MAX_DEF
) (
    spr_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output spr_pkg::t_qitem o_item
);
    import spr_pkg::*;

    logic keep;

    always_comb begin
        unique case (i_in.operation)
            OP_PAT:  keep = 32'(i_in.slot) < PAT_MAX;
            OP_TXT:  keep = 32'(i_in.slot) < TXT_MAX;
            OP_SEQ:  keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full && keep;
    assign o_item.kind = i_in.operation;
    assign o_item.slot = i_in.slot;
    assign o_item.word = i_in.word;
    assign o_item.last = i_in.final_word;

endmodule

// ===== rtl/spr_fifo.sv =====
// ----------------------------------------------------------------------------
// spr_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_fifo #(
    parameter int DEPTH = spr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spr_pkg::t_qitem i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output spr_pkg::t_qitem o_item
);
    import spr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign n_wp    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign n_rp    = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `SPR_ASSERT(a_no_push_full, i_clk, i_rst_n, (r_cnt == CW'(DEPTH)) |-> !i_push, "push into full queue")

endmodule

// ===== rtl/spr_back.sv =====
// ----------------------------------------------------------------------------
// spr_back
// stores, lookahead window, match check and result sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_back #(
    parameter int PAT_MAX = spr_pkg::PAT_MAX_DEF,
    parameter int TXT_MAX = spr_pkg::TXT_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spr_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  spr_pkg::t_qitem i_q_item,
    output logic            o_q_pop,
    spr_out_if.source       o_out
);
    import spr_pkg::*;

    localparam int PAW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int TAW = (TXT_MAX > 1) ? $clog2(TXT_MAX) : 1;
    localparam int PLW = $clog2(PAT_MAX + 1);
    localparam int TLW = $clog2(TXT_MAX + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_WORD  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MTXT  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]               r_state, n_state;
    logic signed [WORD_W-1:0] r_pat [PAT_MAX];
    logic signed [WORD_W-1:0] r_win [PAT_MAX];
    logic signed [WORD_W-1:0] r_txt_mem [TXT_MAX];
    logic signed [WORD_W-1:0] r_txt_q;
    logic [PLW-1:0]           r_fill, n_fill;
    logic                     r_start, n_start;
    logic [PLW-1:0]           r_plen, n_plen;
    logic [TLW-1:0]           r_tlen, n_tlen;
    logic [TAW-1:0]           r_tidx, n_tidx;
    logic signed [WORD_W-1:0] r_word, n_word;
    logic                     r_last, n_last;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_word;
    logic                     r_out_has;
    logic                     r_out_end;

    logic                     adv, match, txt_done;
    logic                     pat_we, txt_we, win_push, win_pop;
    logic                     emit, e_has, e_end;
    logic signed [WORD_W-1:0] e_word;
    logic [PLW-1:0]           plen_cur, fill_base, plen_sat;
    logic [TLW-1:0]           tlen_cur, tlen_sat;
    logic [PAW-1:0]           pat_idx, push_idx;
    logic [TAW-1:0]           txt_idx;

    assign adv      = !r_out_valid || o_out.ready;
    assign txt_done = (TLW'(r_tidx) + TLW'(1)) == r_tlen;
    assign pat_idx  = PAW'(i_q_item.slot);
    assign txt_idx  = TAW'(i_q_item.slot);
    assign plen_sat = (32'(i_cfg.plen) > PAT_MAX) ? PLW'(PAT_MAX) : PLW'(i_cfg.plen);
    assign tlen_sat = (32'(i_cfg.tlen) > TXT_MAX) ? TLW'(TXT_MAX) : TLW'(i_cfg.tlen);

    // window against pattern over the latched length
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < PAT_MAX; i++) begin
            if (PLW'(i) < r_plen && r_win[i] != r_pat[i]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_start   = r_start;
        n_plen    = r_plen;
        n_tlen    = r_tlen;
        n_tidx    = '0;
        n_word    = r_word;
        n_last    = r_last;
        o_q_pop   = 1'b0;
        pat_we    = 1'b0;
        txt_we    = 1'b0;
        win_push  = 1'b0;
        win_pop   = 1'b0;
        emit      = 1'b0;
        e_word    = r_word;
        e_has     = 1'b1;
        e_end     = 1'b0;
        plen_cur  = r_start ? plen_sat : r_plen;
        tlen_cur  = r_start ? tlen_sat : r_tlen;
        fill_base = r_start ? '0 : r_fill;
        push_idx  = fill_base[PAW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.kind)
                        OP_PAT: pat_we = 1'b1;
                        OP_TXT: txt_we = 1'b1;
                        OP_SEQ: begin
                            n_word  = i_q_item.word;
                            n_last  = i_q_item.last;
                            n_start = i_q_item.last;
                            n_plen  = plen_cur;
                            n_tlen  = tlen_cur;
                            if (plen_cur == '0) begin
                                n_fill  = '0;
                                n_state = (r_start && tlen_cur != '0) ? S_PRE : S_WORD;
                            end else begin
                                win_push = 1'b1;
                                n_fill   = fill_base + PLW'(1);
                                n_state  = S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PRE: begin
                n_tidx = r_tidx;
                if (adv) begin
                    emit   = 1'b1;
                    e_word = r_txt_q;
                    if (txt_done) begin
                        n_tidx  = '0;
                        n_state = S_WORD;
                    end else begin
                        n_tidx = r_tidx + TAW'(1);
                    end
                end
            end
            S_WORD: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_word  = r_word;
                    e_end   = r_last;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (r_fill == r_plen) begin
                    if (match) begin
                        n_fill = '0;
                        if (r_tlen != '0) begin
                            n_state = S_MTXT;
                        end else begin
                            n_state = r_last ? S_FLUSH : S_IDLE;
                        end
                    end else if (adv) begin
                        emit    = 1'b1;
                        e_word  = r_win[0];
                        e_end   = r_last && r_fill == PLW'(1);
                        win_pop = 1'b1;
                        n_fill  = r_fill - PLW'(1);
                        n_state = (r_last && r_fill != PLW'(1)) ? S_FLUSH : S_IDLE;
                    end
                end else begin
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_MTXT: begin
                n_tidx = r_tidx;
                if (adv) begin
                    emit   = 1'b1;
                    e_word = r_txt_q;
                    e_end  = r_last && txt_done;
                    if (txt_done) begin
                        n_tidx  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_tidx = r_tidx + TAW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_fill == '0) begin
                        e_word  = '0;
                        e_has   = 1'b0;
                        e_end   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        e_word  = r_win[0];
                        e_end   = r_fill == PLW'(1);
                        win_pop = 1'b1;
                        n_fill  = r_fill - PLW'(1);
                        if (r_fill == PLW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // pattern store and lookahead window
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAT_MAX; i++) begin
            if (pat_we && pat_idx == PAW'(i)) begin
                r_pat[i] <= i_q_item.word;
            end
        end
        if (win_pop) begin
            for (int i = 0; i < PAT_MAX - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
        end
        for (int i = 0; i < PAT_MAX; i++) begin
            if (win_push && push_idx == PAW'(i)) begin
                r_win[i] <= i_q_item.word;
            end
        end
    end

    // text store with registered read and write forwarding
    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            r_txt_mem[txt_idx] <= i_q_item.word;
        end
        if (txt_we && txt_idx == n_tidx) begin
            r_txt_q <= i_q_item.word;
        end else begin
            r_txt_q <= r_txt_mem[n_tidx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (emit) begin
            r_out_word <= e_word;
            r_out_has  <= e_has;
            r_out_end  <= e_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_start     <= 1'b1;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_tidx      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_start <= n_start;
            r_plen  <= n_plen;
            r_tlen  <= n_tlen;
            r_tidx  <= n_tidx;
            r_last  <= n_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_word   = r_out_word;
    assign o_out.has_word   = r_out_has;
    assign o_out.end_of_run = r_out_end;

    `SPR_ASSERT(a_fill_in_range, i_clk, i_rst_n, r_fill <= r_plen, "window fill beyond pattern length")
    `SPR_ASSERT(a_flush_on_last, i_clk, i_rst_n, (r_state == S_FLUSH) |-> r_last, "flush without last word")
    `SPR_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n, emit && e_end, r_start && r_state == S_IDLE, "end of run without restart")

endmodule

// ===== rtl/stream_pattern_replace_core.sv =====
// write request: stored in the back end once taken from the queue
// sequence word: window load, then match check that passes the oldest word on
// match: window check, then the text words in turn; a final word also flushes the window
// text before first word (empty pattern): the text words in turn, then the word itself
// results leave through an output register; a queue of Q_DEPTH requests sits in front
// reset: synchronous, clears control state; pattern and text stores hold until written
// ----------------------------------------------------------------------------
// stream_pattern_replace_core
// leftmost non-overlapping find and replace over a stream of words
// ----------------------------------------------------------------------------
module stream_pattern_replace_core #(
    parameter int PAT_MAX = spr_pkg::PAT_MAX_DEF,
    parameter int TXT_MAX = spr_pkg::TXT_MAX_DEF,
    parameter int Q_DEPTH = spr_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spr_in_if.sink    i_in,
    spr_out_if.source o_out,
    spr_cfg_if.sink   i_cfg
);
    import spr_pkg::*;

    t_cfg   r_cfg;
    t_qitem front_item, q_item;
    logic   front_push, q_full, q_valid, q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PLEN: r_cfg.plen <= i_cfg.data;
                CFG_TLEN: r_cfg.tlen <= i_cfg.data;
                default: ;
            endcase
        end
    end

    spr_front #(
        .PAT_MAX (PAT_MAX),
        .TXT_MAX (TXT_MAX)
    ) u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (front_push),
        .o_item (front_item)
    );

    spr_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    spr_back #(
        .PAT_MAX (PAT_MAX),
        .TXT_MAX (TXT_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
